FILE: hdl/uud_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Unicode code-unit decoder.
// No dependencies; imported by every module of the block.
package uud_pkg;

   typedef struct packed {
      logic [31:0] code_unit;
      logic [2:0]  units_left;
   } req_type;

   typedef struct packed {
      logic [31:0] code_point;
      logic [1:0]  status;
   } rsp_type;

   // unit_mode codes (3 behaves as UTF-32)
   localparam logic [1:0] MODE_UTF8  = 2'd0;
   localparam logic [1:0] MODE_UTF16 = 2'd1;
   localparam logic [1:0] MODE_UTF32 = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_CHAR    = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_TERM    = 2'd2;

   // UTF-8 lead byte bounds
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] LEAD_BAD   = 8'hF8;

   // offsets removed from the shifted-in UTF-8 sequence
   localparam logic [31:0] UTF8_TWO_OFFSET   = 32'h0000_3080;
   localparam logic [31:0] UTF8_THREE_OFFSET = 32'h000E_2080;
   localparam logic [31:0] UTF8_FOUR_OFFSET  = 32'h03C8_2080;

   // UTF-16 surrogate constants
   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;

   // decode stage handshake toward the result register
   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } dec_out_type;

endpackage

FILE: hdl/uud_in_stage.sv
`timescale 1ns / 1ps
// Input register of the decoder: holds one item until the decode stage takes it.
// Depends on uud_pkg.
module uud_in_stage import uud_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    advance,
   output logic    s1_valid,
   output req_type s1_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    take;

   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

endmodule

FILE: hdl/uud_decode.sv
`timescale 1ns / 1ps
// Decode stage: mode register, open-sequence state and the per-unit decode logic.
// Depends on uud_pkg.
module uud_decode import uud_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  req_type     s1_data,
   input  logic        advance,
   output dec_out_type dec_out
);

   logic [1:0]  mode_ff;
   logic [1:0]  pend_ff, pend_in;
   logic [2:0]  len_ff, len_in;
   logic [31:0] acc_ff, acc_in;

   logic [2:0]  left;
   logic [7:0]  b;
   logic [15:0] u;
   logic [31:0] acc_shift;
   logic [31:0] off;
   logic [31:0] surr_hi;
   logic [31:0] surr_cp;
   logic [1:0]  pend_dec;

   assign b = s1_data.code_unit[7:0];
   assign u = s1_data.code_unit[15:0];

   // clamp units_left into 1..4
   always_comb begin
      if (s1_data.units_left == 3'd0) begin
         left = 3'd1;
      end else if (s1_data.units_left > 3'd4) begin
         left = 3'd4;
      end else begin
         left = s1_data.units_left;
      end
   end

   assign acc_shift = {acc_ff[25:0], 6'b0} + {24'b0, b};
   assign pend_dec  = pend_ff - 2'd1;
   assign surr_hi   = acc_ff - {16'b0, HIGH_SURR_LO};
   assign surr_cp   = {surr_hi[21:0], 10'b0}
                      + ({16'b0, u} - {16'b0, LOW_SURR_LO}) + SUPP_BASE;

   always_comb begin
      if (len_ff == 3'd2) begin
         off = UTF8_TWO_OFFSET;
      end else if (len_ff == 3'd3) begin
         off = UTF8_THREE_OFFSET;
      end else begin
         off = UTF8_FOUR_OFFSET;
      end
   end

   always_comb begin
      pend_in                = pend_ff;
      len_in                 = len_ff;
      acc_in                 = acc_ff;
      dec_out.emit           = 1'b0;
      dec_out.rsp.code_point = 32'd0;
      dec_out.rsp.status     = STATUS_CHAR;
      unique case (mode_ff)
         MODE_UTF8: begin
            if (pend_ff != 2'd0) begin
               acc_in  = acc_shift;
               pend_in = pend_dec;
               if (pend_dec == 2'd0) begin
                  dec_out.emit           = 1'b1;
                  dec_out.rsp.code_point = acc_shift - off;
                  len_in                 = 3'd0;
                  acc_in                 = 32'd0;
               end
            end else if (b == 8'd0) begin
               dec_out.emit       = 1'b1;
               dec_out.rsp.status = STATUS_TERM;
            end else if (b < LEAD_TWO) begin
               dec_out.emit           = 1'b1;
               dec_out.rsp.code_point = {24'b0, b};
            end else if (b < LEAD_THREE && left >= 3'd2) begin
               pend_in = 2'd1;
               len_in  = 3'd2;
               acc_in  = {24'b0, b};
            end else if (b < LEAD_FOUR && left >= 3'd3) begin
               pend_in = 2'd2;
               len_in  = 3'd3;
               acc_in  = {24'b0, b};
            end else if (b < LEAD_BAD && left >= 3'd4) begin
               pend_in = 2'd3;
               len_in  = 3'd4;
               acc_in  = {24'b0, b};
            end else begin
               dec_out.emit       = 1'b1;
               dec_out.rsp.status = STATUS_INVALID;
            end
         end
         MODE_UTF16: begin
            if (pend_ff != 2'd0) begin
               // low surrogate taken unchecked
               dec_out.emit           = 1'b1;
               dec_out.rsp.code_point = surr_cp;
               pend_in                = 2'd0;
               len_in                 = 3'd0;
               acc_in                 = 32'd0;
            end else if (u == 16'd0) begin
               dec_out.emit       = 1'b1;
               dec_out.rsp.status = STATUS_TERM;
            end else if (u >= HIGH_SURR_LO && u <= HIGH_SURR_HI) begin
               if (left >= 3'd2) begin
                  pend_in = 2'd1;
                  len_in  = 3'd2;
                  acc_in  = {16'b0, u};
               end else begin
                  dec_out.emit       = 1'b1;
                  dec_out.rsp.status = STATUS_INVALID;
               end
            end else begin
               dec_out.emit           = 1'b1;
               dec_out.rsp.code_point = {16'b0, u};
            end
         end
         default: begin
            dec_out.emit = 1'b1;
            if (s1_data.code_unit == 32'd0) begin
               dec_out.rsp.status = STATUS_TERM;
            end else begin
               dec_out.rsp.code_point = s1_data.code_unit;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UTF8;
         pend_ff <= 2'd0;
         len_ff  <= 3'd0;
         acc_ff  <= 32'd0;
      end else if (csr_wr_en) begin
         // mode change drops any open sequence
         mode_ff <= csr_wr_data;
         pend_ff <= 2'd0;
         len_ff  <= 3'd0;
         acc_ff  <= 32'd0;
      end else if (advance) begin
         pend_ff <= pend_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

FILE: hdl/unicode_unit_decoder.sv
`timescale 1ns / 1ps
// Top level of the streaming Unicode code-unit decoder (UTF-8 / UTF-16 / UTF-32).
// Depends on uud_pkg, uud_in_stage and uud_decode.
//
//   channel   ports                          direction  carries
//   req       req_valid req_stall req_data   in         code_unit, units_left
//   rsp       rsp_valid rsp_stall rsp_data   out        code_point, status
//   csr       csr_wr_en csr_wr_data          in         unit_mode
//
// One item per clock sustained while no result-making item waits behind a held
// result. An item is registered on entry, decoded from the input register by the
// shift-add/subtract logic, and its result (if any) is then registered in the result register.
// Lead units that open a sequence produce no result and never wait on rsp_stall.
// Synchronous reset clears valids, sequence state and sets unit_mode to UTF-8.
// rsp_stall holds the result register; req_stall rises only when a result-making
// item sits in the input register behind a held result.
module unicode_unit_decoder import uud_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   // configuration
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   logic        s1_valid;
   req_type     s1_data;
   logic        advance;
   logic        out_free;
   dec_out_type dec_out;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // result register can take a new item if empty or draining this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // items that make no result move on even behind a held result
   assign advance  = s1_valid && (out_free || !dec_out.emit);

   uud_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data)
   );

   uud_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .s1_data     (s1_data),
      .advance     (advance),
      .dec_out     (dec_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && dec_out.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = dec_out.rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/uud_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for unicode_unit_decoder: tracks unit_mode, predicts code points.
// Compares each accepted result in order. Depends on uud_pkg.
module uud_stream_checker import uud_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output int         fail_count,
   output int         points_outstanding
);

   localparam int MAX_REPORTS = 40;

   // mirror of the decoder state
   logic [1:0]  mode_now     = MODE_UTF8;
   logic [1:0]  seq_pending  = '0;
   logic [2:0]  seq_length   = '0;
   logic [31:0] partial_cp   = '0;
   rsp_type     points_due[$];
   int          errors       = 0;

   function void clear_sequence();
      seq_pending = '0;
      seq_length  = '0;
      partial_cp  = '0;
   endfunction

   function void open_sequence(input logic [2:0] len, input logic [31:0] first);
      seq_length  = len;
      seq_pending = 2'(len - 3'd1);
      partial_cp  = first;
   endfunction

   // Returns 1 when the item yields a code point (or invalid/terminator).
   function bit decode_unit(input req_type item, output rsp_type res);
      logic [2:0]  left;
      logic [7:0]  octet;
      logic [15:0] code16;
      logic [31:0] offset;
      left = (item.units_left == 3'd0) ? 3'd1 :
             (item.units_left > 3'd4) ? 3'd4 : item.units_left;
      res  = '0;
      res.status = STATUS_CHAR;
      case (mode_now)
         MODE_UTF8: begin
            octet = item.code_unit[7:0];
            if (seq_pending != 2'd0) begin
               partial_cp  = (partial_cp << 6) + {24'd0, octet};
               seq_pending = seq_pending - 2'd1;
               if (seq_pending != 2'd0)
                  return 1'b0;
               offset = (seq_length == 3'd2) ? UTF8_TWO_OFFSET :
                        (seq_length == 3'd3) ? UTF8_THREE_OFFSET : UTF8_FOUR_OFFSET;
               res.code_point = partial_cp - offset;
               clear_sequence();
               return 1'b1;
            end
            if (octet == 8'd0) begin
               res.status = STATUS_TERM;
               return 1'b1;
            end
            if (octet < LEAD_TWO) begin
               res.code_point = {24'd0, octet};
               return 1'b1;
            end
            if (octet < LEAD_THREE && left >= 3'd2) begin
               open_sequence(3'd2, {24'd0, octet});
               return 1'b0;
            end
            if (octet < LEAD_FOUR && left >= 3'd3) begin
               open_sequence(3'd3, {24'd0, octet});
               return 1'b0;
            end
            if (octet < LEAD_BAD && left >= 3'd4) begin
               open_sequence(3'd4, {24'd0, octet});
               return 1'b0;
            end
            res.status = STATUS_INVALID;
            return 1'b1;
         end
         MODE_UTF16: begin
            code16 = item.code_unit[15:0];
            if (seq_pending != 2'd0) begin
               // low half taken unchecked
               res.code_point = ((partial_cp - {16'd0, HIGH_SURR_LO}) << 10)
                              + ({16'd0, code16} - {16'd0, LOW_SURR_LO}) + SUPP_BASE;
               clear_sequence();
               return 1'b1;
            end
            if (code16 == 16'd0) begin
               res.status = STATUS_TERM;
               return 1'b1;
            end
            if (code16 >= HIGH_SURR_LO && code16 <= HIGH_SURR_HI) begin
               if (left >= 3'd2) begin
                  open_sequence(3'd2, {16'd0, code16});
                  return 1'b0;
               end
               res.status = STATUS_INVALID;
               return 1'b1;
            end
            res.code_point = {16'd0, code16};
            return 1'b1;
         end
         default: begin
            if (item.code_unit == 32'd0)
               res.status = STATUS_TERM;
            else
               res.code_point = item.code_unit;
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         mode_now = MODE_UTF8;
         clear_sequence();
         points_due.delete();
      end else begin
         // result side first: it never belongs to an item taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (points_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected result, expected none, got %h/%0d",
                           $time, rsp_data.code_point, rsp_data.status);
            end else begin
               want = points_due.pop_front();
               if (rsp_data.code_point !== want.code_point) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: code_point expected %h, got %h",
                              $time, want.code_point, rsp_data.code_point);
               end
               if (rsp_data.status !== want.status) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: status expected %0d, got %0d",
                              $time, want.status, rsp_data.status);
               end
            end
         end
         if (csr_wr_en) begin
            mode_now = csr_wr_data;
            clear_sequence();
         end
         if (req_valid && !req_stall) begin
            if (decode_unit(req_data, predicted))
               points_due.push_back(predicted);
         end
      end
      points_outstanding <= points_due.size();
      fail_count         <= errors;
   end

endmodule

FILE: verif/tb_unicode_unit_decoder.sv
`timescale 1ns / 1ps
// Top of the unicode_unit_decoder testbench: clock, reset, stimulus, verdict.
// Depends on uud_pkg, unicode_unit_decoder and uud_stream_checker.
module tb_unicode_unit_decoder;
   import uud_pkg::*;

   // mode value 3 is not named in the package; it must act like UTF-32
   localparam logic [1:0]  MODE_UTF32_ALIAS = 2'd3;
   // bits of code_unit the decoder looks at in UTF-8 and UTF-16 mode
   localparam logic [31:0] KEEP_BYTE  = 32'h0000_00FF;
   localparam logic [31:0] KEEP_HALF  = 32'h0000_FFFF;
   localparam int SETTLE_CYCLES = 4;     // covers a lead still in flight
   localparam int END_CYCLES    = 8;
   localparam int HOLD_CYCLES   = 100;   // long receiver hold-off
   localparam int HANG_LIMIT    = 2000;  // cycles with no handshake at all

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_wr_data = MODE_UTF8;

   int fail_count;
   int points_outstanding;
   int units_sent   = 0;
   int holds_asked  = 0;
   int holds_done   = 0;
   int hold_left    = 0;
   int idle_cycles  = 0;

   always #1 clock = ~clock;

   unicode_unit_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   uud_stream_checker monitor_u (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .points_outstanding (points_outstanding)
   );

   // Idle profile by progress: sender 35 / receiver 55 percent, then swapped,
   // then a stretch with no idling on either side.
   function automatic int sender_idle_pct();
      if (units_sent < 580)  return 35;
      if (units_sent < 1160) return 55;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (units_sent < 580)  return 55;
      if (units_sent < 1160) return 35;
      return 0;
   endfunction

   // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
   // The hold is counted here so the sender keeps offering items meanwhile.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   // Watchdog: ends the run if no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Random fill of the bits the current mode ignores.
   function automatic logic [31:0] with_noise(input logic [31:0] value,
                                              input logic [31:0] keep);
      return ($urandom() & ~keep) | (value & keep);
   endfunction

   // Offer one item, with random idle cycles first, and hold it until taken.
   task automatic send_unit(input logic [31:0] code_val, input logic [2:0] left);
      int pct;
      pct = sender_idle_pct();
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{code_unit: code_val, units_left: left};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      units_sent++;
   endtask

   // Stop offering, let every expected result arrive, then let a lead unit
   // still in the pipe settle before the mode register is touched.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (points_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed UTF-8 sequences with random content; the rest is terminators,
   // ASCII and stray continuation bytes, bad leads, short buffers and random units.
   task automatic random_utf8(input int n_units);
      int         done;
      int         kind;
      int         len;
      int         i;
      logic [7:0] lead;
      logic [7:0] cont;
      done = 0;
      while (done < n_units) begin
         kind = $urandom_range(99);
         if (kind < 5) begin
            send_unit(with_noise(32'd0, KEEP_BYTE), 3'($urandom_range(7)));
            done++;
         end else if (kind < 30) begin
            send_unit(with_noise($urandom_range(8'hBF, 1), KEEP_BYTE),
                      3'($urandom_range(7)));
            done++;
         end else if (kind < 90) begin
            len  = $urandom_range(4, 2);
            lead = (len == 2) ? 8'($urandom_range(8'hDF, 8'hC0)) :
                   (len == 3) ? 8'($urandom_range(8'hEF, 8'hE0)) :
                                8'($urandom_range(8'hF7, 8'hF0));
            if (kind < 84) begin
               send_unit(with_noise({24'd0, lead}, KEEP_BYTE), 3'($urandom_range(7, len)));
               for (i = 1; i < len; i++) begin
                  // continuation bytes are not checked by the block; mix in junk
                  cont = ($urandom_range(99) < 85) ? 8'(8'h80 | $urandom_range(63))
                                                   : 8'($urandom_range(255));
                  send_unit(with_noise({24'd0, cont}, KEEP_BYTE), 3'($urandom_range(7)));
               end
               done += len;
            end else begin
               // buffer too short for the lead, including a zero count
               send_unit(with_noise({24'd0, lead}, KEEP_BYTE),
                         3'($urandom_range(len - 1)));
               done++;
            end
         end else if (kind < 95) begin
            send_unit(with_noise($urandom_range(8'hFF, 8'hF8), KEEP_BYTE),
                      3'($urandom_range(7)));
            done++;
         end else begin
            send_unit($urandom(), 3'($urandom_range(7)));
            done++;
         end
      end
   endtask

   // Any-value units and surrogate pairs make up most items; terminators and lone high halves fill the rest.
   task automatic random_utf16(input int n_units);
      int          done;
      int          kind;
      logic [15:0] low_half;
      done = 0;
      while (done < n_units) begin
         kind = $urandom_range(99);
         if (kind < 5) begin
            send_unit(with_noise(32'd0, KEEP_HALF), 3'($urandom_range(7)));
            done++;
         end else if (kind < 50) begin
            send_unit($urandom(), 3'($urandom_range(7)));
            done++;
         end else if (kind < 88) begin
            send_unit(with_noise($urandom_range(HIGH_SURR_HI, HIGH_SURR_LO), KEEP_HALF),
                      3'($urandom_range(7, 2)));
            low_half = ($urandom_range(99) < 80) ? 16'($urandom_range(16'hDFFF, LOW_SURR_LO))
                                                 : 16'($urandom_range(16'hFFFF));
            send_unit(with_noise({16'd0, low_half}, KEEP_HALF), 3'($urandom_range(7)));
            done += 2;
         end else begin
            // high half with no room for its partner
            send_unit(with_noise($urandom_range(HIGH_SURR_HI, HIGH_SURR_LO), KEEP_HALF),
                      3'($urandom_range(1)));
            done++;
         end
      end
   endtask

   task automatic random_utf32(input int n_units);
      int i;
      int kind;
      for (i = 0; i < n_units; i++) begin
         kind = $urandom_range(99);
         if (kind < 6)
            send_unit(32'd0, 3'($urandom_range(7)));
         else if (kind < 20)
            send_unit($urandom_range(16'hFFFF), 3'($urandom_range(7)));
         else
            send_unit($urandom(), 3'($urandom_range(7)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: UTF-8 ----
      write_mode(MODE_UTF8);
      send_unit(with_noise(32'h00, KEEP_BYTE), 3'd1);  // terminator while idle
      send_unit(with_noise(32'h80, KEEP_BYTE), 3'd4);  // stray continuation passes as is
      send_unit(with_noise(32'hC3, KEEP_BYTE), 3'd2);  // two-byte sequence
      send_unit(with_noise(32'hA9, KEEP_BYTE), 3'd1);
      send_unit(with_noise(32'hE2, KEEP_BYTE), 3'd3);  // three-byte sequence
      send_unit(with_noise(32'h82, KEEP_BYTE), 3'd2);
      send_unit(with_noise(32'hAC, KEEP_BYTE), 3'd1);
      send_unit(with_noise(32'hF0, KEEP_BYTE), 3'd7);  // four-byte, count saturates
      send_unit(with_noise(32'h9F, KEEP_BYTE), 3'd3);
      send_unit(with_noise(32'h98, KEEP_BYTE), 3'd2);
      send_unit(with_noise(32'h80, KEEP_BYTE), 3'd1);
      send_unit(with_noise(32'hF8, KEEP_BYTE), 3'd4);  // lowest bad lead
      send_unit(with_noise(32'hC2, KEEP_BYTE), 3'd0);  // zero count acts as one
      send_unit(with_noise(32'hE0, KEEP_BYTE), 3'd2);  // too short for three
      send_unit(with_noise(32'hF0, KEEP_BYTE), 3'd3);  // too short for four
      send_unit(with_noise(32'hC2, KEEP_BYTE), 3'd2);  // zero as continuation
      send_unit(with_noise(32'h00, KEEP_BYTE), 3'd1);
      send_unit(with_noise(32'hC2, KEEP_BYTE), 3'd2);  // left open: mode write drops it

      // ---- directed: UTF-16 ----
      write_mode(MODE_UTF16);
      send_unit(with_noise(32'h0000, KEEP_HALF), 3'd1);
      send_unit(with_noise(32'hDBFF, KEEP_HALF), 3'd1);  // high half as last unit
      send_unit(with_noise(32'hD800, KEEP_HALF), 3'd2);  // lowest pair
      send_unit(with_noise(32'hDC00, KEEP_HALF), 3'd1);
      send_unit(with_noise(32'hDBFF, KEEP_HALF), 3'd4);  // partner is not a low half
      send_unit(with_noise(32'h0041, KEEP_HALF), 3'd3);
      send_unit(with_noise(32'hFFFF, KEEP_HALF), 3'd1);
      send_unit(with_noise(32'hD800, KEEP_HALF), 3'd3);  // left open across mode write

      // ---- directed: UTF-32 ----
      write_mode(MODE_UTF32);
      send_unit(32'h0000_0000, 3'd1);
      send_unit(32'hFFFF_FFFF, 3'd7);

      // ---- random phases, one per mode ----
      write_mode(MODE_UTF8);
      random_utf8(600);
      write_mode(MODE_UTF16);
      random_utf16(450);
      write_mode(MODE_UTF32);
      random_utf32(400);
      write_mode(MODE_UTF32_ALIAS);
      // every item makes a result here, so a long hold-off backs up the input
      holds_asked <= holds_asked + 1;
      random_utf32(250);

      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: unicode_unit_decoder.f
hdl/uud_pkg.sv
hdl/uud_in_stage.sv
hdl/uud_decode.sv
hdl/unicode_unit_decoder.sv
verif/uud_stream_checker.sv
verif/tb_unicode_unit_decoder.sv
